// ----- hdl/sensor_bringup_supervisor_assert.svh -----
// Assertion shorthands used by the supervisor RTL.
`ifndef SENSOR_BRINGUP_SUPERVISOR_ASSERT_SVH
`define SENSOR_BRINGUP_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SBS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/sbs_pkg.sv -----
package sbs_pkg;

   localparam int TIME_BITS_DEF  = 32;
   localparam int COUNT_BITS_DEF = 32;

   // event kinds
   localparam logic [1:0] FUNC_QUERY     = 2'd0;
   localparam logic [1:0] FUNC_ATTEMPT   = 2'd1;
   localparam logic [1:0] FUNC_READ_OK   = 2'd2;
   localparam logic [1:0] FUNC_READ_FAIL = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_NOT_ATTEMPTED = 2'd0;
   localparam logic [1:0] STATUS_READY         = 2'd1;
   localparam logic [1:0] STATUS_READY_FAILING = 2'd2;
   localparam logic [1:0] STATUS_UNAVAILABLE   = 2'd3;

   // configuration registers
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RETRY_INTERVAL = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAILURE_LIMIT  = 1'd1;

   localparam logic [31:0] RETRY_INTERVAL_RESET = 32'd1000;
   localparam logic [15:0] FAILURE_LIMIT_RESET  = 16'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] now;
      logic        ok;
   } req_type;

   typedef struct packed {
      logic        should_attempt;
      logic        ready_res;
      logic        dropped;
      logic [1:0]  status;
      logic [31:0] attempts_count;
      logic [31:0] attempt_fail_count;
      logic [31:0] read_ok_count;
      logic [31:0] read_fail_count;
      logic [31:0] fail_streak;
      logic [31:0] drop_count;
   } rsp_type;

endpackage

// ----- hdl/sensor_bringup_supervisor.sv -----
// Sensor bring-up supervisor.
// Input channel req_*: one event item per handshake (query, bring-up result,
// read success, read failure) stamped with the current tick. Result channel
// rsp_*: exactly one result item per event, in order, with the retry decision,
// the status code, the drop flag and six saturating counters.
// Configuration port csr_*: retry_interval (index 0), failure_limit (index 1);
// write only while no event is in flight.
// The result of an accepted event is registered, into the result register or,
// while the receiver stalls, the skid entry. One event per cycle while req_stall
// is low; the supervisor state is updated in the accepting cycle, so the next event sees it.
// A result register plus one skid entry sit on the output: while the receiver
// stalls, one more event is taken into the skid entry, then req_stall rises
// and stays high until the result register drains.
// Reset (synchronous, active high) clears the supervisor state and counters,
// empties the output stages and loads the register defaults (retry interval
// 1000 ticks, failure limit 3).
`include "sensor_bringup_supervisor_assert.svh"

module sensor_bringup_supervisor
   import sbs_pkg::*;
#(
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,

   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int SUM_BITS = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
   localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   typedef logic [COUNT_BITS-1:0] count_type;

   function automatic count_type sat_inc(input count_type v);
      return (&v) ? v : v + 1'b1;
   endfunction

   logic [31:0]          retry_interval_ff, retry_interval_in;
   logic [15:0]          failure_limit_ff, failure_limit_in;

   logic                 up_flag_ff, up_flag_in;
   logic                 tried_flag_ff, tried_flag_in;
   logic [TIME_BITS-1:0] retry_at_ff, retry_at_in;
   count_type            attempts_ff, attempts_in;
   count_type            attempt_fails_ff, attempt_fails_in;
   count_type            read_oks_ff, read_oks_in;
   count_type            read_fails_ff, read_fails_in;
   count_type            streak_ff, streak_in;
   count_type            drops_ff, drops_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   rsp_type              skid_data_ff, skid_data_in;

   logic                 req_accept;
   logic                 rsp_accept;
   logic [TIME_BITS-1:0] now_t;
   logic [SUM_BITS-1:0]  retry_sum;
   logic [TIME_BITS-1:0] retry_sat;
   logic                 dropped_now;
   rsp_type              rsp_next;

   assign req_stall  = skid_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   // configuration writes
   always_comb begin
      retry_interval_in = retry_interval_ff;
      failure_limit_in  = failure_limit_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_RETRY_INTERVAL: retry_interval_in = csr_wdata;
            CSR_FAILURE_LIMIT:  failure_limit_in  = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // event processing
   always_comb begin
      up_flag_in       = up_flag_ff;
      tried_flag_in    = tried_flag_ff;
      retry_at_in      = retry_at_ff;
      attempts_in      = attempts_ff;
      attempt_fails_in = attempt_fails_ff;
      read_oks_in      = read_oks_ff;
      read_fails_in    = read_fails_ff;
      streak_in        = streak_ff;
      drops_in         = drops_ff;
      dropped_now      = 1'b0;

      now_t     = TIME_BITS'(req_data.now);
      retry_sum = SUM_BITS'(now_t) + SUM_BITS'(retry_interval_ff);
      // clamp at the largest tick when the sum leaves the time range
      retry_sat = (retry_sum[SUM_BITS-1:TIME_BITS] != '0) ? TIME_MAX
                                                          : retry_sum[TIME_BITS-1:0];

      if (req_accept) begin
         unique case (req_data.func)
            FUNC_QUERY: ;
            FUNC_ATTEMPT: begin
               tried_flag_in = 1'b1;
               attempts_in   = sat_inc(attempts_ff);
               if (req_data.ok) begin
                  up_flag_in = 1'b1;
                  streak_in  = '0;
               end else begin
                  attempt_fails_in = sat_inc(attempt_fails_ff);
                  retry_at_in      = retry_sat;
               end
            end
            FUNC_READ_OK: begin
               read_oks_in = sat_inc(read_oks_ff);
               streak_in   = '0;
            end
            FUNC_READ_FAIL: begin
               read_fails_in = sat_inc(read_fails_ff);
               streak_in     = sat_inc(streak_ff);
               if (up_flag_ff && (failure_limit_ff != '0) &&
                   (CMP_BITS'(streak_in) >= CMP_BITS'(failure_limit_ff))) begin
                  up_flag_in  = 1'b0;
                  drops_in    = sat_inc(drops_ff);
                  retry_at_in = now_t;
                  dropped_now = 1'b1;
               end
            end
            default: ;
         endcase
      end

      rsp_next.should_attempt = !up_flag_in && (!tried_flag_in || (now_t >= retry_at_in));
      rsp_next.ready_res      = up_flag_in;
      rsp_next.dropped        = dropped_now;
      if (up_flag_in) begin
         rsp_next.status = (streak_in != '0) ? STATUS_READY_FAILING : STATUS_READY;
      end else begin
         rsp_next.status = tried_flag_in ? STATUS_UNAVAILABLE : STATUS_NOT_ATTEMPTED;
      end
      rsp_next.attempts_count     = 32'(attempts_in);
      rsp_next.attempt_fail_count = 32'(attempt_fails_in);
      rsp_next.read_ok_count      = 32'(read_oks_in);
      rsp_next.read_fail_count    = 32'(read_fails_in);
      rsp_next.fail_streak        = 32'(streak_in);
      rsp_next.drop_count         = 32'(drops_in);
   end

   // output register and skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_accept || !rsp_valid_ff) begin
         if (skid_valid_ff) begin
            // drain the skid entry first; no item is taken while it is full
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = req_accept;
            if (req_accept) begin
               rsp_data_in = rsp_next;
            end
         end
      end else if (req_accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_interval_ff <= RETRY_INTERVAL_RESET;
         failure_limit_ff  <= FAILURE_LIMIT_RESET;
         up_flag_ff        <= 1'b0;
         tried_flag_ff     <= 1'b0;
         retry_at_ff       <= '0;
         attempts_ff       <= '0;
         attempt_fails_ff  <= '0;
         read_oks_ff       <= '0;
         read_fails_ff     <= '0;
         streak_ff         <= '0;
         drops_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         retry_interval_ff <= retry_interval_in;
         failure_limit_ff  <= failure_limit_in;
         up_flag_ff        <= up_flag_in;
         tried_flag_ff     <= tried_flag_in;
         retry_at_ff       <= retry_at_in;
         attempts_ff       <= attempts_in;
         attempt_fails_ff  <= attempt_fails_in;
         read_oks_ff       <= read_oks_in;
         read_fails_ff     <= read_fails_in;
         streak_ff         <= streak_in;
         drops_ff          <= drops_in;
         rsp_valid_ff      <= rsp_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   `SBS_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, rsp_valid_ff, "skid entry full while output empty")
   `SBS_ASSERT_NEXT(a_accept_gives_rsp, req_accept, rsp_valid_ff, "accepted item produced no result")
   `SBS_ASSERT_NOW(a_up_implies_tried, up_flag_ff, tried_flag_ff, "sensor up without any bring-up")
   `SBS_ASSERT_NOW(a_drop_unavailable, rsp_valid_ff && rsp_data_ff.dropped, !rsp_data_ff.ready_res && (rsp_data_ff.status == STATUS_UNAVAILABLE), "drop result not unavailable")
   `SBS_ASSERT_NOW(a_ready_no_attempt, rsp_valid_ff && rsp_data_ff.ready_res, !rsp_data_ff.should_attempt, "attempt requested while sensor up")

endmodule
